FILE: rtl/shrm_pkg.sv
// Shared types and constants for the rotating shift-add string hash block.
package shrm_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned CharKeep   = 6;
   localparam int unsigned AccWidth   = 32;
   localparam int unsigned SizeWidth  = 31;
   localparam int unsigned RotAmount  = 5;
   localparam int unsigned DivSteps   = AccWidth;
   localparam int unsigned CountWidth = $clog2(DivSteps);

   localparam logic [CountWidth-1:0] LastStep = CountWidth'(DivSteps - 1);
   localparam logic [SizeWidth-1:0]  SizeReset = SizeWidth'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic acc_update;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic char_zero;
   } status_type;

endpackage

FILE: rtl/shrm_ctrl.sv
// Controller: handshakes, divide step count and the output valid flag.
module shrm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  shrm_pkg::status_type status,
   output shrm_pkg::cmd_type  cmd
);

   shrm_pkg::state_type              state_ff, state_in;
   logic [shrm_pkg::CountWidth-1:0]  count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shrm_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      req_ready      = 1'b0;
      cmd            = '0;

      // drop the output item once taken; a new load below sets it again
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         shrm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.char_zero) begin
                  cmd.div_start = 1'b1;
                  count_in      = '0;
                  state_in      = shrm_pkg::ST_DIVIDE;
               end else begin
                  cmd.acc_update = 1'b1;
               end
            end
         end
         shrm_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == shrm_pkg::LastStep) begin
               state_in = shrm_pkg::ST_PUBLISH;
            end
         end
         shrm_pkg::ST_PUBLISH: begin
            // hold the remainder until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = shrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = shrm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/shrm_dp.sv
// Datapath: hash accumulator, table size register, radix-2 remainder unit.
module shrm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [shrm_pkg::CharWidth-1:0]    req_char_byte,
   input  logic                              csr_write,
   input  logic [shrm_pkg::SizeWidth-1:0]    csr_table_size,
   input  shrm_pkg::cmd_type                 cmd,
   output shrm_pkg::status_type              status,
   output logic [shrm_pkg::SizeWidth-1:0]    rsp_bucket_index
);

   localparam int unsigned AW = shrm_pkg::AccWidth;
   localparam int unsigned SW = shrm_pkg::SizeWidth;
   localparam int unsigned RA = shrm_pkg::RotAmount;
   localparam int unsigned CK = shrm_pkg::CharKeep;

   logic [AW-1:0] acc_ff, acc_in;
   logic [SW-1:0] size_ff, size_in;
   logic [AW-1:0] dvd_ff, dvd_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] bucket_ff, bucket_in;

   logic [AW-1:0] acc_sum;
   logic [AW-1:0] acc_rot;
   logic [SW:0]   rem_shift;
   logic [SW:0]   rem_diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         size_ff <= shrm_pkg::SizeReset;
      end else begin
         acc_ff  <= acc_in;
         size_ff <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      bucket_ff <= bucket_in;
   end

   assign acc_sum   = acc_ff + {{(AW-CK){1'b0}}, req_char_byte[CK-1:0]};
   assign acc_rot   = {acc_sum[AW-RA-1:0], acc_sum[AW-1:AW-RA]};
   assign rem_shift = {rem_ff, dvd_ff[AW-1]};
   assign rem_diff  = rem_shift - {1'b0, size_ff};

   always_comb begin
      acc_in    = acc_ff;
      size_in   = size_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      bucket_in = bucket_ff;

      // a zero size is stored as one so the divisor never vanishes
      if (csr_write) begin
         size_in = (csr_table_size == '0) ? shrm_pkg::SizeReset : csr_table_size;
      end

      if (cmd.acc_update) begin
         acc_in = acc_rot;
      end

      if (cmd.div_start) begin
         dvd_in = acc_ff;
         rem_in = '0;
         acc_in = '0;
      end

      // restoring step: one dividend bit per cycle, MSB first
      if (cmd.div_step) begin
         dvd_in = {dvd_ff[AW-2:0], 1'b0};
         if (rem_shift >= {1'b0, size_ff}) begin
            rem_in = rem_diff[SW-1:0];
         end else begin
            rem_in = rem_shift[SW-1:0];
         end
      end

      if (cmd.out_load) begin
         bucket_in = rem_ff;
      end
   end

   assign status.char_zero = (req_char_byte == '0);
   assign rsp_bucket_index = bucket_ff;

endmodule

FILE: rtl/string_hash_rotate_mod.sv
// A nonzero character is folded into the accumulator; req_ready stays high for it.
// A zero byte starts a restoring remainder unit (one dividend bit per cycle);
// the item shows on rsp_* once the division ends and the output register is free.
// Characters are taken one per cycle while idle; a terminator blocks input until its
// item is loaded into the output register. Reset is synchronous, active high: clears
// the accumulator, sets table size to 1 and drops rsp_valid.
module string_hash_rotate_mod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [shrm_pkg::CharWidth-1:0]  req_char_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [shrm_pkg::SizeWidth-1:0]  rsp_bucket_index,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [shrm_pkg::SizeWidth-1:0]  csr_table_size
);

   shrm_pkg::cmd_type    cmd;
   shrm_pkg::status_type status;

   assign csr_ready = 1'b1;

   shrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   shrm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_char_byte    (req_char_byte),
      .csr_write        (csr_valid),
      .csr_table_size   (csr_table_size),
      .cmd              (cmd),
      .status           (status),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

FILE: rtl/shrm_checker.sv
// Port-level checks for the string hash block, bound to the top level.
module shrm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [shrm_pkg::CharWidth-1:0]  req_char_byte,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [shrm_pkg::SizeWidth-1:0]  rsp_bucket_index
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bucket_index))
      else $error("result item changed while stalled");

   // a terminator blocks input while the remainder is worked out
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_char_byte == '0) |=> !req_ready)
      else $error("input accepted during reduction");

   // a character leaves req_ready high in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_char_byte != '0) |=> req_ready)
      else $error("character stalled the input");

   // a new result appears only at the end of a reduction
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a reduction");

endmodule

bind string_hash_rotate_mod shrm_checker u_shrm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_char_byte    (req_char_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_bucket_index (rsp_bucket_index)
);

FILE: tb/hash_bucket_checker.sv
// Checker for the string hash block: watches all channels and compares bucket results.
module hash_bucket_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [shrm_pkg::CharWidth-1:0] req_char_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [shrm_pkg::SizeWidth-1:0] rsp_bucket_index,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [shrm_pkg::SizeWidth-1:0] csr_table_size,
   output int unsigned                    pending_count,
   output int unsigned                    fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned AccW  = shrm_pkg::AccWidth;
   localparam int unsigned SizeW = shrm_pkg::SizeWidth;
   localparam int unsigned CharW = shrm_pkg::CharWidth;
   localparam int unsigned Keep  = shrm_pkg::CharKeep;
   localparam int unsigned Rot   = shrm_pkg::RotAmount;

   logic [AccW-1:0]  hash_acc;
   logic [SizeW-1:0] bucket_divisor;
   logic [SizeW-1:0] expected_buckets [$];
   int unsigned      errors = 0;

   // add the kept low bits of the character, then rotate left
   function automatic logic [AccW-1:0] mix_char(input logic [AccW-1:0]  acc,
                                                 input logic [CharW-1:0] c);
      logic [AccW-1:0] sum;
      sum = acc + AccW'(c[Keep-1:0]);
      return {sum[AccW-Rot-1:0], sum[AccW-1:AccW-Rot]};
   endfunction

   always @(posedge clock) begin
      logic [SizeW-1:0] want;
      if (reset) begin
         hash_acc       = '0;
         bucket_divisor = shrm_pkg::SizeReset;
         expected_buckets.delete();
      end else begin
         // a zero size is stored as one
         if (csr_valid && csr_ready)
            bucket_divisor = (csr_table_size == '0) ? shrm_pkg::SizeReset : csr_table_size;
         if (rsp_valid && rsp_ready) begin
            if (expected_buckets.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected bucket item %0d", $realtime, rsp_bucket_index);
               errors++;
            end else begin
               want = expected_buckets.pop_front();
               if (rsp_bucket_index !== want) begin
                  if (errors < 10)
                     $display("%0t: bucket mismatch: expected %0d, got %0d",
                              $realtime, want, rsp_bucket_index);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_char_byte == '0) begin
               expected_buckets.push_back(SizeW'(hash_acc % {1'b0, bucket_divisor}));
               hash_acc = '0;
            end else begin
               hash_acc = mix_char(hash_acc, req_char_byte);
            end
         end
      end
      pending_count <= expected_buckets.size();
      fail_count    <= errors;
   end

endmodule

FILE: tb/tb_string_hash_rotate_mod.sv
// Testbench top for the string hash block: stimulus, handshake idling and verdict.
module tb_string_hash_rotate_mod;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DrainPause  = 40;
   localparam int unsigned TargetItems = 550;
   localparam int unsigned Chunks      = 9;
   localparam int unsigned CharW       = shrm_pkg::CharWidth;
   localparam int unsigned SizeW       = shrm_pkg::SizeWidth;
   localparam int unsigned StrBits     = 8*12;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [CharW-1:0] req_char_byte = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [SizeW-1:0] rsp_bucket_index;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [SizeW-1:0] csr_table_size = '0;

   int unsigned pending_count;
   int unsigned fail_count;
   int unsigned send_idle_pct = 28;
   int unsigned recv_idle_pct = 75;
   int unsigned sent_items = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   string_hash_rotate_mod u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_table_size   (csr_table_size)
   );

   hash_bucket_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_table_size   (csr_table_size),
      .pending_count    (pending_count),
      .fail_count       (fail_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // leaves req_valid high after the handshake; the caller lowers it or sends again
   task automatic send_char(input logic [CharW-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= c;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   // bytes go out from the top of the vector; a terminator follows
   task automatic send_bytes(input logic [StrBits-1:0] s, input int n);
      for (int i = n - 1; i >= 0; i--)
         send_char(s[8*i +: 8]);
      send_char('0);
   endtask

   task automatic send_random_string();
      int unsigned len;
      len = ($urandom_range(7) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
         // sometimes a byte whose kept bits are all zero
         if ($urandom_range(9) == 0)
            send_char(CharW'($urandom_range(1, 3) * 64));
         else
            send_char(CharW'($urandom_range(1, 255)));
      end
      send_char('0);
   endtask

   // hold the sender until every bucket has come back, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainPause) @(posedge clock);
   endtask

   task automatic set_table_size(input logic [SizeW-1:0] v);
      drain_results();
      csr_valid      <= 1'b1;
      csr_table_size <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SizeW-1:0] pick_table_size(input int idx);
      case (idx)
         0:       return SizeW'($urandom);
         1:       return SizeW'($urandom_range(1, 16));
         2:       return 31'h4000_0000;
         3:       return SizeW'($urandom_range(1, 1000));
         4:       return 31'h7fff_ffff;
         5:       return '0;
         6:       return SizeW'(3);
         7:       return SizeW'($urandom_range(1, 2) == 1 ? $urandom : 31'h7fff_fffe);
         default: return SizeW'($urandom);
      endcase
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset size of one, then both size extremes and a zero write
      send_bytes('0, 0);
      send_bytes(StrBits'({8'hff, 8'h01}), 2);
      set_table_size(31'h7fff_ffff);
      send_bytes(StrBits'({8'hff, 8'h3f, 8'h40, 8'h80, 8'hc0, 8'h7f, 8'h01, 8'hfe}), 8);
      send_bytes('0, 0);
      set_table_size('0);
      send_bytes(StrBits'({8'h41}), 1);
      set_table_size(SizeW'(2));
      send_bytes(StrBits'({8'h20, 8'h10, 8'h08}), 3);

      sent_items = 0;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 28; recv_idle_pct = 75; end
            1:       begin send_idle_pct = 75; recv_idle_pct = 28; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         for (int k = 0; k < 3; k++) begin
            set_table_size(pick_table_size(ph * 3 + k));
            while (sent_items < (ph * 3 + k + 1) * TargetItems / Chunks) begin
               send_random_string();
               if ($urandom_range(14) == 0)
                  drain_results();
            end
         end
      end

      drain_results();
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #3_200_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
